[rtl/staircase_led_sweep_sequencer_unit_macros.svh]
// Assertion macros shared by the staircase LED sweep sequencer RTL.
`ifndef STAIRCASE_LED_SWEEP_SEQUENCER_UNIT_MACROS_SVH
`define STAIRCASE_LED_SWEEP_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SLSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SLSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/slss_pkg.sv]
// Types, constants and helper functions of the staircase LED sweep sequencer.
package slss_pkg;

  localparam int LED_COUNT = 10;
  localparam int TICK_BITS = 16;

  // Fixed field widths of the streams and the configuration port.
  localparam int LED_W     = 10;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam int IDX_W = $clog2(LED_COUNT + 1);
  localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;
  localparam int PAT_EXT_W = (LED_COUNT > LED_W) ? LED_COUNT : LED_W;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] STEP_TICKS_RST = CFG_W'(100);
  localparam logic [CFG_W-1:0] HOLD_TICKS_RST = CFG_W'(2000);

  localparam logic [LED_COUNT-1:0] FULL_MASK = {LED_COUNT{1'b1}};
  localparam logic [CMP_W-1:0]     TICK_MAX  = CMP_W'((64'd1 << TICK_BITS) - 64'd1);
  localparam logic [IDX_W-1:0]     LAST_STEP = IDX_W'(LED_COUNT);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_FILL  = 4'b0010,
    PH_HOLD  = 4'b0100,
    PH_CLEAR = 4'b1000
  } phase_e;

  // Pattern with k LEDs lit, counted from the bottom or from the top end.
  function automatic logic [LED_COUNT-1:0] lit_from_end(logic [IDX_W-1:0] k, logic top);
    logic [LED_COUNT-1:0] res;
    res = '0;
    for (int i = 0; i < LED_COUNT; i++) begin
      if (top) begin
        res[i] = (i >= LED_COUNT - int'(k));
      end else begin
        res[i] = (i < int'(k));
      end
    end
    return res;
  endfunction

  // Limit a threshold to what the tick counter can reach.
  function automatic logic [CMP_W-1:0] clamp_thresh(logic [CFG_W-1:0] thr);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(thr);
    return (ext > TICK_MAX) ? TICK_MAX : ext;
  endfunction

endpackage

[rtl/staircase_led_sweep_sequencer_unit.sv]
// Top level of the staircase LED sweep sequencer: phase control and result register.
//
// Usage: every transfer on the slave stream is one 1 ms tick carrying the four
// sensor levels; each tick gives exactly one transfer on the master stream with
// the 10-LED pattern and the busy flag. A bottom or top trigger while idle starts
// a fill sweep, then a hold of the full pattern unless hold_ticks is zero, then a
// clear sweep in the same direction. While idle the LEDs are all on exactly when
// light and presence are both asserted.
// The result of each input transfer is registered in the output register. Throughput is
// one tick per cycle while the receiver takes results: the phase, step and tick counter
// updates are combinational logic between the state registers and the output register.
// The configuration channel (index 0 step_ticks, index 1 hold_ticks) is always
// ready; other indexes are ignored. Writes belong to idle periods.
// Reset clears the sequence state to idle with all LEDs off and loads step_ticks
// 100 and hold_ticks 2000. When the receiver stalls, the output register holds
// its result and s_axis_tready drops until that result has been taken.
`include "staircase_led_sweep_sequencer_unit_macros.svh"

module staircase_led_sweep_sequencer_unit import slss_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Slave stream of sensor ticks.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: [0] bottom_trigger, [1] top_trigger, [2] light_sense, [3] presence_sense
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Master stream of LED results.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: [9:0] led_pattern, [10] busy_res
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  logic [CFG_W-1:0] step_ticks_q;
  logic [CFG_W-1:0] hold_ticks_q;

  phase_e               phase_q, phase_d;
  logic                 from_top_q, from_top_d;
  logic [IDX_W-1:0]     step_idx_q, step_idx_d;
  logic [TICK_BITS-1:0] tick_cnt_q, tick_cnt_d;
  logic [LED_COUNT-1:0] pattern_q, pattern_d;
  logic                 busy_d;

  logic                 out_valid_q;
  logic [LED_W-1:0]     out_led_q;
  logic                 out_busy_q;

  logic                 in_xfer;
  logic                 bot_trig, top_trig, light, presence;
  logic [CFG_W-1:0]     step_eff;
  logic [CMP_W-1:0]     step_thr, hold_thr, cnt_ext, cnt_inc;
  logic                 step_hit, hold_hit;
  logic [PAT_EXT_W-1:0] pat_ext;

  assign bot_trig = s_axis_tdata[0];
  assign top_trig = s_axis_tdata[1];
  assign light    = s_axis_tdata[2];
  assign presence = s_axis_tdata[3];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Saturating tick counter and threshold compares.
  assign step_eff = (step_ticks_q == '0) ? CFG_W'(1) : step_ticks_q;
  assign step_thr = clamp_thresh(step_eff);
  assign hold_thr = clamp_thresh(hold_ticks_q);
  assign cnt_ext  = CMP_W'(tick_cnt_q);
  assign cnt_inc  = (cnt_ext < TICK_MAX) ? cnt_ext + CMP_W'(1) : cnt_ext;
  assign step_hit = (cnt_inc >= step_thr);
  assign hold_hit = (cnt_inc >= hold_thr);

  always_comb begin
    phase_d    = phase_q;
    from_top_d = from_top_q;
    step_idx_d = step_idx_q;
    tick_cnt_d = tick_cnt_q;
    pattern_d  = pattern_q;
    busy_d     = 1'b1;
    case (phase_q)
      PH_IDLE: begin
        if (bot_trig || top_trig) begin
          from_top_d = !bot_trig;
          phase_d    = PH_FILL;
          step_idx_d = '0;
          tick_cnt_d = '0;
        end else begin
          pattern_d = (light && presence) ? FULL_MASK : '0;
          busy_d    = 1'b0;
        end
      end
      PH_FILL: begin
        tick_cnt_d = TICK_BITS'(cnt_inc);
        if (step_hit) begin
          tick_cnt_d = '0;
          pattern_d  = lit_from_end(step_idx_q, from_top_q);
          if (step_idx_q == LAST_STEP) begin
            step_idx_d = '0;
            phase_d    = (hold_ticks_q == '0) ? PH_CLEAR : PH_HOLD;
          end else begin
            step_idx_d = step_idx_q + IDX_W'(1);
          end
        end
      end
      PH_HOLD: begin
        tick_cnt_d = TICK_BITS'(cnt_inc);
        if (hold_hit) begin
          tick_cnt_d = '0;
          phase_d    = PH_CLEAR;
        end
      end
      PH_CLEAR: begin
        tick_cnt_d = TICK_BITS'(cnt_inc);
        if (step_hit) begin
          tick_cnt_d = '0;
          pattern_d  = FULL_MASK & ~lit_from_end(step_idx_q, from_top_q);
          if (step_idx_q == LAST_STEP) begin
            step_idx_d = '0;
            phase_d    = PH_IDLE;
          end else begin
            step_idx_d = step_idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  assign pat_ext = PAT_EXT_W'(pattern_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ticks_q <= STEP_TICKS_RST;
      hold_ticks_q <= HOLD_TICKS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_STEP_TICKS) begin
        step_ticks_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_HOLD_TICKS) begin
        hold_ticks_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      from_top_q  <= 1'b0;
      step_idx_q  <= '0;
      tick_cnt_q  <= '0;
      pattern_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_q     <= phase_d;
        from_top_q  <= from_top_d;
        step_idx_q  <= step_idx_d;
        tick_cnt_q  <= tick_cnt_d;
        pattern_q   <= pattern_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_led_q  <= pat_ext[LED_W-1:0];
      out_busy_q <= busy_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_busy_q, out_led_q});

  // The input side only stalls behind a result the receiver has not taken.
  `SLSS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !s_axis_tready,
    m_axis_tvalid && !m_axis_tready, "input stalled without a pending result")

  // The sweep step index never runs past the last pattern.
  `SLSS_ASSERT_NOW(a_step_range, clk_i, rst_ni, 1'b1,
    step_idx_q <= LAST_STEP, "step index out of range")

  // An untriggered idle tick reports not busy.
  `SLSS_ASSERT_NEXT(a_idle_not_busy, clk_i, rst_ni,
    in_xfer && (phase_q == PH_IDLE) && !bot_trig && !top_trig,
    !out_busy_q && (phase_q == PH_IDLE), "idle tick reported busy")

  // A trigger on an accepted idle tick always starts a fill at step zero.
  `SLSS_ASSERT_NEXT(a_start_on_trigger, clk_i, rst_ni,
    in_xfer && (phase_q == PH_IDLE) && (bot_trig || top_trig),
    (phase_q == PH_FILL) && out_busy_q && (step_idx_q == '0), "trigger did not start a fill")

endmodule

[test/tb.sv]
// Self-checking testbench for the staircase LED sweep sequencer unit.
`timescale 1ns / 100ps

module tb;
  import slss_pkg::*;

  // Tracks the sweep state of the block and the LED results it must produce.
  class led_sweep_scoreboard;
    logic [CFG_W-1:0] step_reg;
    logic [CFG_W-1:0] hold_reg;
    phase_e           phase;
    bit               from_top;
    int unsigned      step_idx;
    int unsigned      tick_cnt;
    logic [LED_W-1:0] pattern;
    logic [LED_W:0]   expected_q[$];  // {busy_res, led_pattern}
    int unsigned      errors;

    function new();
      step_reg = STEP_TICKS_RST;
      hold_reg = HOLD_TICKS_RST;
      phase    = PH_IDLE;
      from_top = 1'b0;
      step_idx = 0;
      tick_cnt = 0;
      pattern  = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_STEP_TICKS: step_reg = data;
        CFG_HOLD_TICKS: hold_reg = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // LED pattern with k LEDs lit, counted from the end that started the sweep.
    function logic [LED_W-1:0] lit_count(int unsigned k);
      logic [LED_W-1:0] full;
      full = '1;
      if (from_top) return full ^ (full >> k);
      return full & ~(full << k);
    endfunction

    // The tick counter saturates, and so does the threshold it is compared with.
    function bit tick_reached(int unsigned limit);
      if (limit > TICK_MAX) limit = TICK_MAX;
      if (tick_cnt < TICK_MAX) tick_cnt++;
      return tick_cnt >= limit;
    endfunction

    function void note_tick(logic bot, logic top, logic light, logic pres);
      logic        busy;
      int unsigned step_lim;
      busy     = 1'b1;
      step_lim = (step_reg == 0) ? 1 : step_reg;
      case (phase)
        PH_IDLE: begin
          if (bot || top) begin
            from_top = !bot;
            phase    = PH_FILL;
            step_idx = 0;
            tick_cnt = 0;
          end else begin
            pattern = (light && pres) ? '1 : '0;
            busy    = 1'b0;
          end
        end
        PH_FILL: begin
          if (tick_reached(step_lim)) begin
            tick_cnt = 0;
            pattern  = lit_count(step_idx);
            step_idx++;
            if (step_idx > LED_COUNT) begin
              step_idx = 0;
              phase    = (hold_reg == 0) ? PH_CLEAR : PH_HOLD;
            end
          end
        end
        PH_HOLD: begin
          if (tick_reached(hold_reg)) begin
            tick_cnt = 0;
            phase    = PH_CLEAR;
          end
        end
        default: begin
          if (tick_reached(step_lim)) begin
            tick_cnt = 0;
            pattern  = ~lit_count(step_idx);
            step_idx++;
            if (step_idx > LED_COUNT) begin
              step_idx = 0;
              phase    = PH_IDLE;
            end
          end
        end
      endcase
      expected_q.push_back({busy, pattern});
    endfunction

    function void flag(string what, logic [OUT_TDATA_W-1:0] expv,
                       logic [OUT_TDATA_W-1:0] actv);
      errors++;
      if (errors <= 10)
        $display("tb: mismatch on %s: expected 0x%0h, got 0x%0h", what, expv, actv);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      logic [LED_W:0] exp_item;
      if (expected_q.size() == 0) begin
        flag("unexpected result", '0, data);
        return;
      end
      exp_item = expected_q.pop_front();
      if (data[LED_W-1:0] !== exp_item[LED_W-1:0])
        flag("led_pattern", exp_item[LED_W-1:0], data[LED_W-1:0]);
      if (data[LED_W] !== exp_item[LED_W])
        flag("busy_res", exp_item[LED_W], data[LED_W]);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  led_sweep_scoreboard sb = new();
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;

  staircase_led_sweep_sequencer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Result side: check every transfer and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_idling(int unsigned mode);
    case (mode % 4)
      0: begin send_gap_pct = 0;  stall_pct = 0;  end
      1: begin send_gap_pct = 87; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 87; end
      default: begin send_gap_pct = 13; stall_pct = 13; end
    endcase
  endtask

  // Valid is left high on return so that back-to-back ticks need no gap.
  task automatic send_tick(logic bot, logic top, logic light, logic pres);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, pres, light, top, bot};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(bot, top, light, pres);
  endtask

  // Sensors and triggers at random; quiet ticks keep triggers rare.
  task automatic random_tick(bit noisy);
    logic trig, bot, top;
    if (noisy) begin
      send_tick($urandom_range(1), $urandom_range(1), $urandom_range(1), $urandom_range(1));
    end else begin
      trig = ($urandom_range(15) == 0);
      bot  = trig && $urandom_range(1);
      top  = trig && (!bot || $urandom_range(1));
      send_tick(bot, top, $urandom_range(1), $urandom_range(1));
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // With more set, valid stays high for the next register write.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data, bit more);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    if (!more) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_W-1:0] step, logic [CFG_W-1:0] hold, bit more);
    drain_results();
    cfg_write(CFG_STEP_TICKS, step, 1'b1);
    cfg_write(CFG_HOLD_TICKS, hold, more);
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned seg;
    int unsigned seg_len;
    bit          noisy;
    bit          extra;
    logic [CFG_W-1:0] step_v;
    logic [CFG_W-1:0] hold_v;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle output follows light and presence; both triggers at once favor the bottom.
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1);
    // Reset step_ticks of 100 puts the first sweep step a hundred ticks out.
    repeat (101) random_tick(1'b1);

    // Zero step_ticks mid-sweep acts as one step per tick; zero hold skips the hold.
    drain_results();
    cfg_write(CFG_STEP_TICKS, '0, 1'b1);
    cfg_write(CFG_HOLD_TICKS, '0, 1'b1);
    cfg_write(CFG_IDX_W'($urandom_range(2, 15)), CFG_W'($urandom), 1'b0);
    repeat (24) random_tick(1'b1);

    // Top sweep with a short hold.
    set_regs(16'd1, 16'd3, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    repeat (36) random_tick(1'b1);

    // Largest thresholds, shortened mid-sequence so the run stays short.
    set_idling(3);
    set_regs('1, '1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    repeat (40) random_tick(1'b1);
    drain_results();
    cfg_write(CFG_STEP_TICKS, 16'd1, 1'b0);
    repeat (45) random_tick(1'b1);
    drain_results();
    cfg_write(CFG_HOLD_TICKS, '0, 1'b0);
    repeat (16) random_tick(1'b1);

    rand_items = 0;
    seg = 0;
    while (rand_items < 1530) begin
      set_idling(seg);
      step_v = ($urandom_range(7) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(1, 4));
      hold_v = $urandom_range(1) ? CFG_W'(0) : CFG_W'($urandom_range(1, 12));
      extra  = ($urandom_range(3) == 0);
      set_regs(step_v, hold_v, extra);
      if (extra)
        cfg_write(CFG_IDX_W'($urandom_range(2, 15)), CFG_W'($urandom), 1'b0);
      noisy   = ($urandom_range(4) == 0);
      seg_len = $urandom_range(40, 120);
      repeat (seg_len) random_tick(noisy);
      rand_items += seg_len;
      seg++;
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
